### src/r2y_pkg.sv
// ----------------------------------------------------------------------------
// r2y_pkg: shared constants and helpers for the rgb to yuyv packer
// Fixed-point bt.601 full-range coefficients (scaled by 2^16) and the
// per-pixel luma and chroma functions.
// ----------------------------------------------------------------------------
package r2y_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned FracW = 16;
  localparam int unsigned AccW  = 25;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [AccW-1:0] acc_t;

  // luma weights, sum to 2^16 so white maps to 255
  localparam logic [15:0] Y_KR = 16'd19595;
  localparam logic [15:0] Y_KG = 16'd38470;
  localparam logic [15:0] Y_KB = 16'd7471;

  // chroma weights
  localparam logic [15:0] C_HALF = 16'd32768;
  localparam logic [15:0] U_KR   = 16'd11056;
  localparam logic [15:0] U_KG   = 16'd21712;
  localparam logic [15:0] V_KG   = 16'd27440;
  localparam logic [15:0] V_KB   = 16'd5328;

  // 128 << 16, the chroma offset
  localparam acc_t C_OFFSET = acc_t'(25'd8388608);

  // luma, truncated
  function automatic pix_t luma_of(pix_t r, pix_t g, pix_t b);
    acc_t acc;
    acc = acc_t'(Y_KR) * acc_t'(r) + acc_t'(Y_KG) * acc_t'(g)
        + acc_t'(Y_KB) * acc_t'(b);
    return acc[FracW +: PixW];
  endfunction

  // blue difference plus 128, truncated; the sum never leaves [0, 2^24)
  function automatic pix_t cb_of(pix_t r, pix_t g, pix_t b);
    acc_t acc;
    acc = C_OFFSET + acc_t'(C_HALF) * acc_t'(b)
        - acc_t'(U_KR) * acc_t'(r) - acc_t'(U_KG) * acc_t'(g);
    return acc[FracW +: PixW];
  endfunction

  // red difference plus 128, truncated
  function automatic pix_t cr_of(pix_t r, pix_t g, pix_t b);
    acc_t acc;
    acc = C_OFFSET + acc_t'(C_HALF) * acc_t'(r)
        - acc_t'(V_KG) * acc_t'(g) - acc_t'(V_KB) * acc_t'(b);
    return acc[FracW +: PixW];
  endfunction

endpackage

### src/rgb_to_yuyv_packer.sv
// ----------------------------------------------------------------------------
// rgb_to_yuyv_packer: rgb pixel stream to packed yuyv 4:2:2 words
// Pairs incoming pixels and emits one Y0 U Y1 V word per completed pair.
// ----------------------------------------------------------------------------
// One pixel beat is accepted every clock while no completing pixel waits on a
// full result register. Each pixel goes through an input register and then
// one stage of constant multiplies into the result register, so out_valid
// rises once the beat that completes its pair has passed both. The first pixel
// of a pair gives no result; its Y, U+128 and V+128 are held and chroma of
// the second pixel is discarded (no averaging). A beat with in_image_start
// set drops any held pixel and starts a new pair. Only a completing pixel
// waits on out_ready, and only while the result register is still full.
module rgb_to_yuyv_packer
  import r2y_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic       in_image_start,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_luma_first,
  output logic [7:0] out_chroma_blue,
  output logic [7:0] out_luma_second,
  output logic [7:0] out_chroma_red
);

  // input register
  logic s1_vld_r, s1_vld_nxt;
  pix_t s1_red_r, s1_green_r, s1_blue_r;
  logic s1_start_r;

  // pairing state
  logic hold_r, hold_nxt;
  pix_t held_y_r, held_u_r, held_v_r;

  // result register
  logic out_vld_r, out_vld_nxt;
  pix_t out_y0_r, out_u_r, out_y1_r, out_v_r;

  logic is_first;
  logic s1_go;
  logic out_free;
  pix_t cur_y, cur_u, cur_v;

  // conversion of the registered pixel
  assign cur_y = luma_of(s1_red_r, s1_green_r, s1_blue_r);
  assign cur_u = cb_of(s1_red_r, s1_green_r, s1_blue_r);
  assign cur_v = cr_of(s1_red_r, s1_green_r, s1_blue_r);

  // advance control
  assign is_first = s1_start_r | ~hold_r;
  assign out_free = ~out_vld_r | out_ready;
  assign s1_go    = s1_vld_r & (is_first | out_free);
  assign in_ready = ~s1_vld_r | s1_go;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_ready) begin
      s1_vld_nxt = in_valid;
    end
    hold_nxt = hold_r;
    if (s1_go) begin
      hold_nxt = is_first;
    end
    out_vld_nxt = out_vld_r & ~out_ready;
    if (s1_go && !is_first) begin
      out_vld_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      hold_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      hold_r    <= hold_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_start_r <= in_image_start;
    end
  end

  // held first pixel and packed result
  always_ff @(posedge clk) begin
    if (s1_go && is_first) begin
      held_y_r <= cur_y;
      held_u_r <= cur_u;
      held_v_r <= cur_v;
    end
    if (s1_go && !is_first) begin
      out_y0_r <= held_y_r;
      out_u_r  <= held_u_r;
      out_y1_r <= cur_y;
      out_v_r  <= held_v_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_luma_first  = out_y0_r;
  assign out_chroma_blue = out_u_r;
  assign out_luma_second = out_y1_r;
  assign out_chroma_red  = out_v_r;

endmodule

### bench/rgb_to_yuyv_packer_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_yuyv_packer_tb: self-checking bench for the rgb to yuyv packer
// Drives pixel beats (directed corners, then random images with stray
// image-start flags) under changing idle patterns and a long output
// hold-off. Predicts each packed yuyv word and checks the output field by field.
// ----------------------------------------------------------------------------
module rgb_to_yuyv_packer_tb;
  import r2y_pkg::*;

  localparam int unsigned StallLimit    = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBeats    = 630;
  localparam int unsigned PressureAt    = 1500;

  // bt.601 full-range weights in 16-bit fractions
  localparam int LumaWtR   = 19595;
  localparam int LumaWtG   = 38470;
  localparam int LumaWtB   = 7471;
  localparam int ChromaWt  = 32768;
  localparam int CbWtR     = 11056;
  localparam int CbWtG     = 21712;
  localparam int CrWtG     = 27440;
  localparam int CrWtB     = 5328;
  localparam int ChromaOfs = 128 * 65536;

  typedef struct packed {
    pix_t y0;
    pix_t cb;
    pix_t y1;
    pix_t cr;
  } yuyv_word_t;

  // pairs pixels as the block does and keeps the words still to come
  class yuyv_scoreboard;
    bit         pair_open;
    pix_t       open_y;
    pix_t       open_cb;
    pix_t       open_cr;
    yuyv_word_t words_due[$];
    int         errors;

    function pix_t luma_8(pix_t r, pix_t g, pix_t b);
      int sum;
      sum = LumaWtR * int'(r) + LumaWtG * int'(g) + LumaWtB * int'(b);
      return pix_t'(sum >>> 16);
    endfunction

    function pix_t cb_8(pix_t r, pix_t g, pix_t b);
      int sum;
      sum = ChromaOfs + ChromaWt * int'(b) - CbWtR * int'(r) - CbWtG * int'(g);
      return pix_t'(sum >>> 16);
    endfunction

    function pix_t cr_8(pix_t r, pix_t g, pix_t b);
      int sum;
      sum = ChromaOfs + ChromaWt * int'(r) - CrWtG * int'(g) - CrWtB * int'(b);
      return pix_t'(sum >>> 16);
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    // accepted pixel beat: hold it or close the pair
    function void note_pixel(pix_t r, pix_t g, pix_t b, logic start);
      yuyv_word_t w;
      if (start)
        pair_open = 1'b0;
      if (!pair_open) begin
        open_y    = luma_8(r, g, b);
        open_cb   = cb_8(r, g, b);
        open_cr   = cr_8(r, g, b);
        pair_open = 1'b1;
      end else begin
        w.y0 = open_y;
        w.cb = open_cb;
        w.y1 = luma_8(r, g, b);
        w.cr = open_cr;
        words_due.push_back(w);
        pair_open = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // accepted output beat against the oldest word due
    task check_word(pix_t y0, pix_t cb, pix_t y1, pix_t cr);
      yuyv_word_t want;
      if (words_due.size() == 0) begin
        report($sformatf("word %h %h %h %h with none due", y0, cb, y1, cr));
        return;
      end
      want = words_due.pop_front();
      if (y0 != want.y0)
        report($sformatf("luma_first got %h want %h", y0, want.y0));
      if (cb != want.cb)
        report($sformatf("chroma_blue got %h want %h", cb, want.cb));
      if (y1 != want.y1)
        report($sformatf("luma_second got %h want %h", y1, want.y1));
      if (cr != want.cr)
        report($sformatf("chroma_red got %h want %h", cr, want.cr));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_red = '0;
  pix_t in_green = '0;
  pix_t in_blue = '0;
  logic in_image_start = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  pix_t out_luma_first;
  pix_t out_chroma_blue;
  pix_t out_luma_second;
  pix_t out_chroma_red;

  int unsigned tx_idle_pct = 17;
  int unsigned rx_idle_pct = 68;
  logic        hold_off = 1'b0;
  int unsigned pixels_in = 0;
  int unsigned quiet_cycles = 0;

  yuyv_scoreboard sb;

  rgb_to_yuyv_packer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_image_start (in_image_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma_first (out_luma_first),
    .out_chroma_blue(out_chroma_blue),
    .out_luma_second(out_luma_second),
    .out_chroma_red (out_chroma_red)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // send one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b,
                            input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    in_image_start <= start;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // channel value biased toward the extremes
  function automatic pix_t rand_channel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return 8'd0;
    if (pick == 1)
      return 8'd255;
    return pix_t'($urandom_range(255));
  endfunction

  // one image: start flag on its first pixel, a few stray starts inside
  task automatic send_image(output int unsigned beats);
    int unsigned len;
    logic        start;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
    for (int unsigned i = 0; i < len; i++) begin
      start = (i == 0) || ($urandom_range(99) < 4);
      send_pixel(rand_channel(), rand_channel(), rand_channel(), start);
    end
    beats = len;
  endtask

  // receiver: random stalls, forced low during the hold-off
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
  end

  // beat monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_pixel(in_red, in_green, in_blue, in_image_start);
      pixels_in <= pixels_in + 1;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_luma_first, out_chroma_blue, out_luma_second, out_chroma_red);
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // long output hold-off while pixels keep coming, to back up the input
  initial begin
    wait (pixels_in >= PressureAt);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // reset, directed pixels, random images in three idle phases, drain
  initial begin
    int unsigned sent;
    int unsigned beats;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // color corners and pairing
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
    // start of image drops a held pixel
    send_pixel(8'd0,   8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0,   8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
    // start with nothing held
    send_pixel(8'd1,   8'd2,   8'd3,   1'b1);
    send_pixel(8'd254, 8'd253, 8'd252, 1'b0);
    // odd pixel at image end, dropped by the next images
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
    send_pixel(8'd170, 8'd85,  8'd170, 1'b0);
    send_pixel(8'd85,  8'd170, 8'd85,  1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      tx_idle_pct <= (phase == 0) ? 17 : (phase == 1) ? 68 : 0;
      rx_idle_pct <= (phase == 0) ? 68 : (phase == 1) ? 17 : 0;
      sent = 0;
      while (sent < PhaseBeats) begin
        send_image(beats);
        sent += beats;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
